[rtl/cnvp_pkg.sv]
// ----------------------------------------------------------------------------
// cnvp_pkg
// Shared types, codes and saturating helpers for the numeral value parser.
// ----------------------------------------------------------------------------
package cnvp_pkg;

	localparam logic [62:0] INT_SAT         = {63{1'b1}};
	localparam logic [62:0] LIM_TEN         = INT_SAT / 63'd10;
	localparam logic [62:0] LIM_TEN_K       = INT_SAT / 63'd10000;
	localparam logic [62:0] LIM_HUNDRED_M   = INT_SAT / 63'd100000000;
	localparam logic [4:0]  MAX_FRAC_DIGITS = 5'd18;
	localparam logic [3:0]  DIGIT_MAX       = 4'd9;

	typedef enum logic [2:0] {
		KIND_DIGIT         = 3'd0,
		KIND_TEN           = 3'd1,
		KIND_HUNDRED       = 3'd2,
		KIND_THOUSAND      = 3'd3,
		KIND_TEN_THOUSAND  = 3'd4,
		KIND_HUNDRED_MILL  = 3'd5,
		KIND_POINT         = 3'd6
	} kind_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [3:0] digit_value;
		logic       last_token;
	} tok_t;

	typedef struct packed {
		logic [62:0] integer_value;
		logic        has_point;
		logic [59:0] fraction_digits;
		logic [4:0]  fraction_length;
		logic        overflow;
	} res_t;

	// Running state of one numeral segment; values never exceed INT_SAT.
	typedef struct packed {
		logic [62:0] run_val;
		logic        only_digits;
		logic [62:0] total_val;
		logic [62:0] section_val;
		logic [3:0]  pend_digit;
		logic        pend_valid;
		logic        after_point;
		logic        frac_stopped;
		logic [59:0] frac_accum;
		logic [4:0]  frac_count;
		logic        ovf_seen;
		logic        run_sat;
		logic        unit_sat;
	} acc_state_t;

	localparam acc_state_t ACC_RESET = '{
		run_val: '0, only_digits: 1'b1, total_val: '0, section_val: '0,
		pend_digit: '0, pend_valid: 1'b0, after_point: 1'b0,
		frac_stopped: 1'b0, frac_accum: '0, frac_count: '0,
		ovf_seen: 1'b0, run_sat: 1'b0, unit_sat: 1'b0
	};

	// Result is {saturated, value}
	function automatic logic [63:0] sat_add(input logic [62:0] a, input logic [62:0] b);
		logic [63:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[63] ? {1'b1, INT_SAT} : s;
	endfunction

	// k is always a literal, so the product maps to shift-adds
	function automatic logic [63:0] sat_mul(input logic [62:0] a, input logic [62:0] k,
			input logic [62:0] lim);
		logic [62:0] p;
		p = a * k;
		return (a > lim) ? {1'b1, INT_SAT} : {1'b0, p};
	endfunction

endpackage

[rtl/cnvp_accum.sv]
// ----------------------------------------------------------------------------
// cnvp_accum
// Segment state registers and the combinational per-token update.
// ----------------------------------------------------------------------------
module cnvp_accum import cnvp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  tok_t       tok,
	output acc_state_t nxt
);

	acc_state_t  st_q;
	logic [3:0]  d;
	logic [63:0] run_m;
	logic [63:0] run_a;
	logic [3:0]  n_small;
	logic [13:0] small_unit;
	logic [62:0] small_prod;
	logic [63:0] sec_a;
	logic [3:0]  n_big;
	logic [63:0] sum_b;
	logic [63:0] mul_tk;
	logic [63:0] mul_hm;
	logic [63:0] big_prod;
	logic [63:0] tot_a;

	assign d = (tok.digit_value > DIGIT_MAX) ? DIGIT_MAX : tok.digit_value;

	always_comb begin
		run_m   = sat_mul(st_q.run_val, 63'd10, LIM_TEN);
		run_a   = sat_add(run_m[62:0], {59'd0, d});

		n_small = st_q.pend_valid ? st_q.pend_digit : 4'd1;
		unique case (kind_t'(tok.token_kind))
			KIND_HUNDRED:  small_unit = 14'd100;
			KIND_THOUSAND: small_unit = 14'd1000;
			default:       small_unit = 14'd10;
		endcase
		small_prod = {49'd0, 14'(n_small) * small_unit};
		sec_a      = sat_add(st_q.section_val, small_prod);

		n_big    = st_q.pend_valid ? st_q.pend_digit : 4'd0;
		sum_b    = sat_add(st_q.section_val, {59'd0, n_big});
		mul_tk   = sat_mul(sum_b[62:0], 63'd10000, LIM_TEN_K);
		mul_hm   = sat_mul(sum_b[62:0], 63'd100000000, LIM_HUNDRED_M);
		big_prod = (kind_t'(tok.token_kind) == KIND_HUNDRED_MILL) ? mul_hm : mul_tk;
		tot_a    = sat_add(st_q.total_val, big_prod[62:0]);

		nxt = st_q;
		if (st_q.after_point) begin
			if (!st_q.frac_stopped) begin
				if (kind_t'(tok.token_kind) == KIND_DIGIT) begin
					if (st_q.frac_count < MAX_FRAC_DIGITS) begin
						nxt.frac_accum = 60'(st_q.frac_accum * 60'd10) + {56'd0, d};
						nxt.frac_count = st_q.frac_count + 5'd1;
					end else begin
						nxt.ovf_seen = 1'b1;
					end
				end else begin
					nxt.frac_stopped = 1'b1;
				end
			end
		end else begin
			unique case (kind_t'(tok.token_kind))
				KIND_DIGIT: begin
					nxt.run_val    = run_a[62:0];
					nxt.run_sat    = st_q.run_sat | run_m[63] | run_a[63];
					nxt.pend_digit = d;
					nxt.pend_valid = 1'b1;
				end
				KIND_TEN, KIND_HUNDRED, KIND_THOUSAND: begin
					nxt.only_digits = 1'b0;
					nxt.pend_valid  = 1'b0;
					nxt.section_val = sec_a[62:0];
					nxt.unit_sat    = st_q.unit_sat | sec_a[63];
				end
				KIND_TEN_THOUSAND, KIND_HUNDRED_MILL: begin
					nxt.only_digits = 1'b0;
					nxt.pend_valid  = 1'b0;
					nxt.section_val = '0;
					nxt.total_val   = tot_a[62:0];
					nxt.unit_sat    = st_q.unit_sat | sum_b[63] | big_prod[63] | tot_a[63];
				end
				KIND_POINT: begin
					nxt.after_point = 1'b1;
				end
				default: begin
					nxt.only_digits = 1'b0;
				end
			endcase
		end
	end

	// the last token of a segment hands its state on and starts afresh
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ACC_RESET;
		end else if (step) begin
			st_q <= tok.last_token ? ACC_RESET : nxt;
		end
	end

endmodule

[rtl/cnvp_finish.sv]
// ----------------------------------------------------------------------------
// cnvp_finish
// Picks the integer path and folds section and pending digit into the result.
// ----------------------------------------------------------------------------
module cnvp_finish import cnvp_pkg::*; (
	input  acc_state_t snap,
	output res_t       res
);

	logic [63:0] ts;
	logic [63:0] tsp;
	logic [3:0]  p;
	logic        ovf;

	always_comb begin
		p   = snap.pend_valid ? snap.pend_digit : 4'd0;
		ts  = sat_add(snap.total_val, snap.section_val);
		tsp = sat_add(ts[62:0], {59'd0, p});
		if (snap.only_digits) begin
			res.integer_value = snap.run_val;
			ovf               = snap.run_sat;
		end else begin
			res.integer_value = tsp[62:0];
			ovf               = snap.unit_sat | ts[63] | tsp[63];
		end
		res.has_point       = snap.after_point;
		res.fraction_digits = snap.frac_accum;
		res.fraction_length = snap.frac_count;
		res.overflow        = ovf | snap.ovf_seen;
	end

endmodule

[rtl/chinese_numeral_value_parser_top.sv]
// ----------------------------------------------------------------------------
// chinese_numeral_value_parser_top
// Token-stream numeral parser: integer, fraction digits and overflow per segment.
// ----------------------------------------------------------------------------
// One token is taken every cycle while the input is not stalled, whatever the
// token kind; the rate rests on the combinational state update in cnvp_accum,
// which holds the whole running state of the segment. The token marking the
// end of a segment passes through the input register, the snapshot stage and
// the result register before its result appears. Non-final tokens never stall
// on the output side; a final token waits only if the snapshot and result
// registers are both full and the result is stalled.
module chinese_numeral_value_parser_top import cnvp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic tok_valid,
	output logic tok_stall,
	input  tok_t tok,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic       valid_s1;
	tok_t       tok_s1;
	logic       valid_s2;
	acc_state_t snap_s2;
	logic       res_valid_q;
	res_t       res_q;

	acc_state_t nxt;
	res_t       fin;
	logic       out_free;
	logic       s2_free;
	logic       s1_adv;
	logic       s1_free;

	assign out_free  = !res_valid_q || !res_stall;
	assign s2_free   = !valid_s2 || out_free;
	assign s1_adv    = valid_s1 && (!tok_s1.last_token || s2_free);
	assign s1_free   = !valid_s1 || s1_adv;
	assign tok_stall = !s1_free;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	cnvp_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_adv),
		.tok    (tok_s1),
		.nxt    (nxt)
	);

	cnvp_finish u_finish (
		.snap (snap_s2),
		.res  (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= tok_valid;
			end
			if (s2_free) begin
				valid_s2 <= s1_adv && tok_s1.last_token;
			end
			if (out_free) begin
				res_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && tok_valid) begin
			tok_s1 <= tok;
		end
		if (s1_adv && tok_s1.last_token) begin
			snap_s2 <= nxt;
		end
		if (out_free && valid_s2) begin
			res_q <= fin;
		end
	end

	// input side only backs up behind a final token
	a_stall_needs_final: assert property (@(posedge clk) disable iff (!arst_n)
		tok_stall |-> (valid_s1 && tok_s1.last_token && valid_s2 && res_valid_q))
		else $error("input stalled without a blocked final token");

	a_snapshot_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_free) |=> (valid_s2 && $stable(snap_s2)))
		else $error("snapshot beat lost while result stalled");

	a_frac_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.fraction_length <= MAX_FRAC_DIGITS))
		else $error("fraction length beyond limit");

	a_frac_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.fraction_length == 5'd0)) |-> (res_q.fraction_digits == 60'd0))
		else $error("fraction digits without length");

endmodule

[bench/tb_chinese_numeral_value_parser_top.sv]
// ----------------------------------------------------------------------------
// tb_chinese_numeral_value_parser_top
// Self-checking bench: walks a short token table, then random numeral segments
// through the parser while both sides stall at random. Every result beat is
// checked field by field against a table row or a token-level model in the bench.
// ----------------------------------------------------------------------------
module tb_chinese_numeral_value_parser_top import cnvp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 20;
	localparam int RAND_ITEMS   = 1700;
	localparam int IDLE_PCT     = 36;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CAP    = 4000;
	localparam int LIMIT_CYCLES = 400000;

	// kind code outside the classified set
	localparam logic [2:0]  KIND_OTHER = 3'd7;
	localparam logic [63:0] SAT64      = {1'b0, INT_SAT};

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] digit;
		logic       last;
		logic       typed;
		res_t       want;
	} dir_row_t;

	localparam res_t NONE = '0;
	localparam int   N_DIR = 26;

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{KIND_DIGIT,        4'd0,  1'b1, 1'b1, '{63'd0,  1'b0, 60'd0, 5'd0, 1'b0}},
		'{KIND_DIGIT,        4'd15, 1'b1, 1'b1, '{63'd9,  1'b0, 60'd0, 5'd0, 1'b0}},
		'{KIND_POINT,        4'd0,  1'b1, 1'b1, '{63'd0,  1'b1, 60'd0, 5'd0, 1'b0}},
		'{KIND_TEN,          4'd7,  1'b1, 1'b1, '{63'd10, 1'b0, 60'd0, 5'd0, 1'b0}},
		'{KIND_TEN_THOUSAND, 4'd0,  1'b1, 1'b1, '{63'd0,  1'b0, 60'd0, 5'd0, 1'b0}},
		'{KIND_OTHER,        4'd15, 1'b1, 1'b1, '{63'd0,  1'b0, 60'd0, 5'd0, 1'b0}},
		// mixed units, two digits in a row at the tail
		'{KIND_DIGIT,        4'd3,  1'b0, 1'b0, NONE},
		'{KIND_HUNDRED_MILL, 4'd0,  1'b0, 1'b0, NONE},
		'{KIND_DIGIT,        4'd5,  1'b0, 1'b0, NONE},
		'{KIND_TEN_THOUSAND, 4'd0,  1'b0, 1'b0, NONE},
		'{KIND_DIGIT,        4'd2,  1'b0, 1'b0, NONE},
		'{KIND_THOUSAND,     4'd0,  1'b0, 1'b0, NONE},
		'{KIND_DIGIT,        4'd4,  1'b0, 1'b0, NONE},
		'{KIND_HUNDRED,      4'd0,  1'b0, 1'b0, NONE},
		'{KIND_DIGIT,        4'd1,  1'b0, 1'b0, NONE},
		'{KIND_DIGIT,        4'd6,  1'b1, 1'b0, NONE},
		// second point stops the fraction
		'{KIND_DIGIT,        4'd1,  1'b0, 1'b0, NONE},
		'{KIND_POINT,        4'd0,  1'b0, 1'b0, NONE},
		'{KIND_DIGIT,        4'd0,  1'b0, 1'b0, NONE},
		'{KIND_DIGIT,        4'd7,  1'b0, 1'b0, NONE},
		'{KIND_POINT,        4'd0,  1'b0, 1'b0, NONE},
		'{KIND_DIGIT,        4'd3,  1'b1, 1'b0, NONE},
		// unit after the point leaves the integer alone
		'{KIND_DIGIT,        4'd2,  1'b0, 1'b0, NONE},
		'{KIND_POINT,        4'd0,  1'b0, 1'b0, NONE},
		'{KIND_DIGIT,        4'd4,  1'b0, 1'b0, NONE},
		'{KIND_THOUSAND,     4'd0,  1'b1, 1'b0, NONE}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic tok_valid;
	logic tok_stall;
	tok_t tok;
	logic res_valid;
	logic res_stall;
	res_t res;

	chinese_numeral_value_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// bench copy of the segment state
	logic [63:0] num_run, num_total, num_section;
	logic [3:0]  num_pend;
	logic        num_pend_ok, num_digits_only, num_in_frac, num_frac_done;
	logic [59:0] num_frac;
	logic [4:0]  num_frac_len;
	logic        num_frac_drop, num_run_sat, num_unit_sat;

	res_t parsed_numerals [$];
	tok_t seg_q [$];
	int   errors;
	bit   calm;
	bit   hold_req;
	res_t want;

	function automatic logic [64:0] clip_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > {1'b0, SAT64})
			return {1'b1, SAT64};
		return {1'b0, s[63:0]};
	endfunction

	function automatic logic [64:0] clip_mul(input logic [63:0] a, input logic [63:0] k);
		if (a > SAT64 / k)
			return {1'b1, SAT64};
		return {1'b0, a * k};
	endfunction

	function automatic logic [63:0] unit_weight(input logic [2:0] kind);
		case (kind)
		KIND_TEN:          return 64'd10;
		KIND_HUNDRED:      return 64'd100;
		KIND_THOUSAND:     return 64'd1000;
		KIND_TEN_THOUSAND: return 64'd10000;
		default:           return 64'd100000000;
		endcase
	endfunction

	task automatic clear_numeral();
		num_run         = '0;
		num_total       = '0;
		num_section     = '0;
		num_pend        = '0;
		num_pend_ok     = 1'b0;
		num_digits_only = 1'b1;
		num_in_frac     = 1'b0;
		num_frac_done   = 1'b0;
		num_frac        = '0;
		num_frac_len    = '0;
		num_frac_drop   = 1'b0;
		num_run_sat     = 1'b0;
		num_unit_sat    = 1'b0;
	endtask

	task automatic step_numeral(input tok_t t, output bit got, output res_t r);
		logic [2:0]  kind;
		logic [63:0] d, n, iv;
		logic [64:0] x, y, z;
		logic        f;
		kind = t.token_kind;
		d    = {60'd0, (t.digit_value > DIGIT_MAX) ? DIGIT_MAX : t.digit_value};
		got  = 1'b0;
		r    = '0;
		if (num_in_frac) begin
			if (!num_frac_done) begin
				if (kind == KIND_DIGIT) begin
					if (num_frac_len < MAX_FRAC_DIGITS) begin
						num_frac     = num_frac * 60'd10 + d[59:0];
						num_frac_len = num_frac_len + 5'd1;
					end else begin
						num_frac_drop = 1'b1;
					end
				end else begin
					num_frac_done = 1'b1;
				end
			end
		end else begin
			case (kind)
			KIND_DIGIT: begin
				x           = clip_mul(num_run, 64'd10);
				y           = clip_add(x[63:0], d);
				num_run     = y[63:0];
				num_run_sat = num_run_sat | x[64] | y[64];
				num_pend    = d[3:0];
				num_pend_ok = 1'b1;
			end
			KIND_TEN, KIND_HUNDRED, KIND_THOUSAND: begin
				// bare unit counts as one of it
				num_digits_only = 1'b0;
				n               = num_pend_ok ? {60'd0, num_pend} : 64'd1;
				num_pend_ok     = 1'b0;
				x               = clip_mul(n, unit_weight(kind));
				y               = clip_add(num_section, x[63:0]);
				num_section     = y[63:0];
				num_unit_sat    = num_unit_sat | x[64] | y[64];
			end
			KIND_TEN_THOUSAND, KIND_HUNDRED_MILL: begin
				num_digits_only = 1'b0;
				n               = num_pend_ok ? {60'd0, num_pend} : 64'd0;
				num_pend_ok     = 1'b0;
				x               = clip_add(num_section, n);
				y               = clip_mul(x[63:0], unit_weight(kind));
				z               = clip_add(num_total, y[63:0]);
				num_total       = z[63:0];
				num_section     = '0;
				num_unit_sat    = num_unit_sat | x[64] | y[64] | z[64];
			end
			KIND_POINT: num_in_frac = 1'b1;
			default:    num_digits_only = 1'b0;
			endcase
		end
		if (t.last_token) begin
			got = 1'b1;
			if (num_digits_only) begin
				iv = num_run;
				f  = num_run_sat;
			end else begin
				x  = clip_add(num_total, num_section);
				y  = clip_add(x[63:0], num_pend_ok ? {60'd0, num_pend} : 64'd0);
				iv = y[63:0];
				f  = num_unit_sat | x[64] | y[64];
			end
			r.integer_value   = iv[62:0];
			r.has_point       = num_in_frac;
			r.fraction_digits = num_frac;
			r.fraction_length = num_frac_len;
			r.overflow        = f | num_frac_drop;
			clear_numeral();
		end
	endtask

	function automatic bit side_idles();
		return !calm && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic logic [3:0] rand_digit();
		if ($urandom_range(15) == 0)
			return 4'($urandom_range(15, 10));
		return 4'($urandom_range(9));
	endfunction

	// entered and left at a falling edge
	task automatic push_token(input tok_t t, input logic typed, input res_t lit);
		bit   got;
		res_t r;
		while (side_idles()) begin
			tok_valid = 1'b0;
			@(negedge clk);
		end
		tok_valid = 1'b1;
		tok       = t;
		do
			@(posedge clk);
		while (tok_stall);
		step_numeral(t, got, r);
		if (got)
			parsed_numerals.insert(parsed_numerals.size(), typed ? lit : r);
		@(negedge clk);
	endtask

	task automatic add_tok(input logic [2:0] kind, input logic [3:0] digit);
		tok_t t;
		t.token_kind  = kind;
		t.digit_value = digit;
		t.last_token  = 1'b0;
		seg_q.insert(seg_q.size(), t);
	endtask

	task automatic add_section();
		if ($urandom_range(1)) begin
			add_tok(KIND_DIGIT, rand_digit());
			add_tok(KIND_THOUSAND, 4'($urandom_range(15)));
		end
		if ($urandom_range(3) == 0)
			add_tok(KIND_DIGIT, 4'd0);
		if ($urandom_range(1)) begin
			add_tok(KIND_DIGIT, rand_digit());
			add_tok(KIND_HUNDRED, 4'($urandom_range(15)));
		end
		if ($urandom_range(1)) begin
			if ($urandom_range(3) != 0)
				add_tok(KIND_DIGIT, rand_digit());
			add_tok(KIND_TEN, 4'($urandom_range(15)));
		end
		if ($urandom_range(1))
			add_tok(KIND_DIGIT, rand_digit());
	endtask

	task automatic compose_numeral();
		int pick;
		seg_q.delete();
		pick = $urandom_range(99);
		if (pick < 55) begin
			if ($urandom_range(2) == 0) begin
				add_section();
				add_tok(KIND_HUNDRED_MILL, 4'($urandom_range(15)));
			end
			if ($urandom_range(1)) begin
				add_section();
				add_tok(KIND_TEN_THOUSAND, 4'($urandom_range(15)));
			end
			add_section();
			if ($urandom_range(3) == 0) begin
				add_tok(KIND_POINT, 4'($urandom_range(15)));
				repeat ($urandom_range(5)) add_tok(KIND_DIGIT, rand_digit());
				if ($urandom_range(2) == 0) begin
					add_tok(3'($urandom_range(7, 1)), 4'($urandom_range(15)));
					add_tok(KIND_DIGIT, rand_digit());
				end
			end
		end else if (pick < 68) begin
			// long digit run, can saturate from 19 digits on
			repeat ($urandom_range(22, 10)) add_tok(KIND_DIGIT, rand_digit());
			if ($urandom_range(3) == 0) begin
				add_tok(KIND_POINT, 4'($urandom_range(15)));
				repeat ($urandom_range(4)) add_tok(KIND_DIGIT, rand_digit());
			end
		end else if (pick < 80) begin
			if ($urandom_range(1))
				add_tok(KIND_DIGIT, rand_digit());
			add_tok(KIND_POINT, 4'($urandom_range(15)));
			repeat ($urandom_range(22, 12)) add_tok(KIND_DIGIT, rand_digit());
		end else begin
			repeat ($urandom_range(8, 1))
				add_tok(3'($urandom_range(7)), 4'($urandom_range(15)));
		end
		if (seg_q.size() == 0)
			add_tok(KIND_DIGIT, rand_digit());
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (parsed_numerals.size() == 0) begin
				$error("result beat with no numeral pending: int %0d", res.integer_value);
				errors++;
			end else begin
				want = parsed_numerals.pop_front();
				check_field("integer_value", 64'(want.integer_value),
					64'(res.integer_value));
				check_field("has_point", 64'(want.has_point), 64'(res.has_point));
				check_field("fraction_digits", 64'(want.fraction_digits),
					64'(res.fraction_digits));
				check_field("fraction_length", 64'(want.fraction_length),
					64'(res.fraction_length));
				check_field("overflow", 64'(want.overflow), 64'(res.overflow));
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_stall = 1'b1;
				for (int i = 0; i < HOLD_CYCLES; i++)
					@(negedge clk);
				hold_req = 1'b0;
			end
			res_stall = side_idles();
		end
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("chinese_numeral_value_parser_top: mismatch");
		$finish;
	end

	initial begin
		int   sent;
		bit   held;
		tok_t t;
		arst_n    = 1'b0;
		tok_valid = 1'b0;
		tok       = '0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		errors    = 0;
		held      = 1'b0;
		sent      = 0;
		clear_numeral();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			t.token_kind  = DIR_ROWS[i].kind;
			t.digit_value = DIR_ROWS[i].digit;
			t.last_token  = DIR_ROWS[i].last;
			push_token(t, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		end

		while (sent < RAND_ITEMS) begin
			calm = (sent >= 700) && (sent < 1000);
			if (sent >= 800 && !held) begin
				hold_req = 1'b1;
				held     = 1'b1;
			end
			compose_numeral();
			for (int i = 0; i < seg_q.size(); i++) begin
				t            = seg_q[i];
				t.last_token = (i == seg_q.size() - 1);
				push_token(t, 1'b0, NONE);
			end
			sent += seg_q.size();
		end
		tok_valid = 1'b0;
		calm      = 1'b0;

		for (int w = 0; w < DRAIN_CAP && parsed_numerals.size() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (parsed_numerals.size() != 0) begin
			$error("%0d numerals never came out", parsed_numerals.size());
			errors++;
		end
		if (errors == 0)
			$display("chinese_numeral_value_parser_top: match");
		else
			$display("chinese_numeral_value_parser_top: mismatch");
		$finish;
	end

endmodule

[files.f]
rtl/cnvp_pkg.sv
rtl/cnvp_accum.sv
rtl/cnvp_finish.sv
rtl/chinese_numeral_value_parser_top.sv
bench/tb_chinese_numeral_value_parser_top.sv
